// ===== hw/rtl/bitwise_expression_lexer_defines.svh =====
// Assertion macros used by the checker file bel_checker.sv.
`ifndef BITWISE_EXPRESSION_LEXER_DEFINES_SVH
`define BITWISE_EXPRESSION_LEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BEL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Lexer port check failed in the same cycle.");

// Next-cycle implication, checked outside reset.
`define BEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Lexer port check failed in the following cycle.");

`endif

// ===== hw/rtl/bel_pkg.sv =====
package bel_pkg;

  localparam int VALUE_BITS = 31;
  localparam int PROD_BITS  = VALUE_BITS + 5;
  localparam int CHAR_BITS  = 8;
  localparam int KIND_BITS  = 3;
  localparam int ERR_BITS   = 3;
  localparam int OUT_BITS   = KIND_BITS + VALUE_BITS + ERR_BITS;
  localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_BITS-1:0] KIND_NUMBER = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_AND    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_OR     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ERROR  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_END    = 3'd4;

  localparam logic [ERR_BITS-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_BITS-1:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY_HEX = 3'd2;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY_BIN = 3'd3;
  localparam logic [ERR_BITS-1:0] ERR_NONBINARY = 3'd4;
  localparam logic [ERR_BITS-1:0] ERR_OVERFLOW  = 3'd5;

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_BITS-1:0] CH_UB    = 8'h42;
  localparam logic [CHAR_BITS-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_BITS-1:0] CH_BAR   = 8'h7C;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LF_HEX = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UF    = 8'h46;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_LEAD = 6'b000010,
    MODE_HEX  = 6'b000100,
    MODE_BIN  = 6'b001000,
    MODE_DEC  = 6'b010000,
    MODE_DROP = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [ERR_BITS-1:0]   error_code;
    logic [VALUE_BITS-1:0] number_value;
    logic [KIND_BITS-1:0]  token_kind;
  } token_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    token_t tok;
  } entry_t;

endpackage

// ===== hw/rtl/bitwise_expression_lexer.sv =====
// Each accepted character is first registered, then lexed into the token queue.
// Throughput: one character per cycle while the queue has room for two tokens; a
// character closing a number and starting a token yields two, which leave one at a time.
// A four-entry token queue parts the lexer from the output side.
// Reset (rst_n low, synchronous) empties the pipeline and returns to idle.
module bitwise_expression_lexer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bel_pkg::CHAR_BITS-1:0]    in_tdata,   // char_code[7:0]
  input  logic                             in_tuser,   // end_of_text
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bel_pkg::OUT_DATA_BITS-1:0] out_tdata, // token_kind, number_value, error_code
  output logic                             out_tlast
);

  logic                           in_valid_r;
  logic [bel_pkg::CHAR_BITS-1:0]  char_r;
  logic                           eot_r;

  bel_pkg::mode_t                 mode_r, mode_nxt;
  logic [3:0]                     lead_r, lead_nxt;
  logic [bel_pkg::VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                           seen_r, seen_nxt;

  bel_pkg::entry_t                fifo_r [bel_pkg::FIFO_DEPTH];
  logic [bel_pkg::PTR_BITS-1:0]   rd_ptr_r, wr_ptr_r;
  logic [bel_pkg::CNT_BITS-1:0]   cnt_r;

  bel_pkg::entry_t                res_a, res_b;
  logic                           proc;
  logic                           pop;
  logic [1:0]                     push_cnt;

  logic                           is_ws, is_dig, is_bin;
  logic                           is_hex_lc, is_hex_uc;
  logic [3:0]                     dig;
  logic [bel_pkg::VALUE_BITS-1:0] acc_in;
  logic [bel_pkg::PROD_BITS-1:0]  acc_ext, prod, sum;
  logic                           ovf;

  bel_pkg::entry_t                fr_res;
  bel_pkg::mode_t                 fr_mode;

  assign proc      = in_valid_r && (cnt_r <= bel_pkg::CNT_BITS'(bel_pkg::FIFO_DEPTH - 2));
  assign in_tready = !in_valid_r || proc;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      eot_r  <= in_tuser;
    end
  end

  always_comb begin
    is_ws     = (char_r == bel_pkg::CH_SPACE) || (char_r == bel_pkg::CH_TAB) ||
                (char_r == bel_pkg::CH_LF) || (char_r == bel_pkg::CH_CR);
    is_dig    = (char_r >= bel_pkg::CH_ZERO) && (char_r <= bel_pkg::CH_NINE);
    is_bin    = (char_r == bel_pkg::CH_ZERO) || (char_r == bel_pkg::CH_ONE);
    is_hex_lc = (char_r >= bel_pkg::CH_LA) && (char_r <= bel_pkg::CH_LF_HEX);
    is_hex_uc = (char_r >= bel_pkg::CH_UA) && (char_r <= bel_pkg::CH_UF);
    dig       = is_dig ? char_r[3:0] : 4'(char_r[3:0] + 4'd9);
    acc_in    = (mode_r == bel_pkg::MODE_LEAD) ? bel_pkg::VALUE_BITS'(lead_r) : acc_r;
    acc_ext   = bel_pkg::PROD_BITS'(acc_in);
    case (mode_r)
      bel_pkg::MODE_HEX: prod = acc_ext << 4;
      bel_pkg::MODE_BIN: prod = acc_ext << 1;
      default:           prod = (acc_ext << 3) + (acc_ext << 1);
    endcase
    sum = prod + bel_pkg::PROD_BITS'(dig);
    ovf = |sum[bel_pkg::PROD_BITS-1:bel_pkg::VALUE_BITS];
  end

  // Token that a character yields when it starts a fresh token.
  always_comb begin
    fr_res = '0;
    fr_mode = bel_pkg::MODE_IDLE;
    if (is_ws) begin
      fr_mode = bel_pkg::MODE_IDLE;
    end else if (is_dig) begin
      fr_mode = bel_pkg::MODE_LEAD;
    end else if (char_r == bel_pkg::CH_AMP) begin
      fr_res.valid = 1'b1;
      fr_res.tok.token_kind = bel_pkg::KIND_AND;
    end else if (char_r == bel_pkg::CH_BAR) begin
      fr_res.valid = 1'b1;
      fr_res.tok.token_kind = bel_pkg::KIND_OR;
    end else begin
      fr_res.valid = 1'b1;
      fr_res.tok.token_kind = bel_pkg::KIND_ERROR;
      fr_res.tok.error_code = bel_pkg::ERR_BAD_CHAR;
      fr_mode = bel_pkg::MODE_DROP;
    end
  end

  always_comb begin
    bel_pkg::entry_t num_tok, err_tok, end_tok;
    num_tok = '0;
    num_tok.valid = 1'b1;
    num_tok.tok.token_kind = bel_pkg::KIND_NUMBER;
    num_tok.tok.number_value = (mode_r == bel_pkg::MODE_LEAD) ?
                               bel_pkg::VALUE_BITS'(lead_r) : acc_r;
    err_tok = '0;
    err_tok.valid = 1'b1;
    err_tok.tok.token_kind = bel_pkg::KIND_ERROR;
    end_tok = '0;
    end_tok.valid = 1'b1;
    end_tok.tok.token_kind = bel_pkg::KIND_END;

    res_a    = '0;
    res_b    = '0;
    mode_nxt = mode_r;
    lead_nxt = lead_r;
    acc_nxt  = acc_r;
    seen_nxt = seen_r;

    if (eot_r) begin
      mode_nxt = bel_pkg::MODE_IDLE;
      lead_nxt = '0;
      acc_nxt  = '0;
      seen_nxt = 1'b0;
      res_a    = end_tok;
      unique case (mode_r)
        bel_pkg::MODE_LEAD, bel_pkg::MODE_DEC: begin
          res_a = num_tok;
          res_b = end_tok;
        end
        bel_pkg::MODE_HEX, bel_pkg::MODE_BIN: begin
          if (seen_r) begin
            res_a = num_tok;
          end else begin
            res_a = err_tok;
            res_a.tok.error_code = (mode_r == bel_pkg::MODE_HEX) ?
                                   bel_pkg::ERR_EMPTY_HEX : bel_pkg::ERR_EMPTY_BIN;
          end
          res_b = end_tok;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (mode_r)
        bel_pkg::MODE_IDLE: begin
          res_a    = fr_res;
          mode_nxt = fr_mode;
          lead_nxt = is_dig ? char_r[3:0] : lead_r;
        end
        bel_pkg::MODE_LEAD: begin
          if ((char_r == bel_pkg::CH_LX) || (char_r == bel_pkg::CH_UX)) begin
            mode_nxt = bel_pkg::MODE_HEX;
            acc_nxt  = '0;
            seen_nxt = 1'b0;
          end else if ((char_r == bel_pkg::CH_LB) || (char_r == bel_pkg::CH_UB)) begin
            mode_nxt = bel_pkg::MODE_BIN;
            acc_nxt  = '0;
            seen_nxt = 1'b0;
          end else if (is_dig) begin
            seen_nxt = 1'b0;
            if (ovf) begin
              res_a    = err_tok;
              res_a.tok.error_code = bel_pkg::ERR_OVERFLOW;
              mode_nxt = bel_pkg::MODE_DROP;
              acc_nxt  = acc_in;
            end else begin
              mode_nxt = bel_pkg::MODE_DEC;
              acc_nxt  = sum[bel_pkg::VALUE_BITS-1:0];
            end
          end else begin
            res_a    = num_tok;
            res_b    = fr_res;
            mode_nxt = fr_mode;
            lead_nxt = is_dig ? char_r[3:0] : lead_r;
          end
        end
        bel_pkg::MODE_HEX, bel_pkg::MODE_BIN, bel_pkg::MODE_DEC: begin
          if ((mode_r == bel_pkg::MODE_HEX && (is_dig || is_hex_lc || is_hex_uc)) ||
              (mode_r == bel_pkg::MODE_BIN && is_bin) ||
              (mode_r == bel_pkg::MODE_DEC && is_dig)) begin
            seen_nxt = 1'b1;
            if (ovf) begin
              res_a    = err_tok;
              res_a.tok.error_code = bel_pkg::ERR_OVERFLOW;
              mode_nxt = bel_pkg::MODE_DROP;
            end else begin
              acc_nxt = sum[bel_pkg::VALUE_BITS-1:0];
            end
          end else if (mode_r == bel_pkg::MODE_BIN && is_dig) begin
            res_a    = err_tok;
            res_a.tok.error_code = bel_pkg::ERR_NONBINARY;
            mode_nxt = bel_pkg::MODE_DROP;
          end else if (mode_r != bel_pkg::MODE_DEC && !seen_r) begin
            res_a    = err_tok;
            res_a.tok.error_code = (mode_r == bel_pkg::MODE_HEX) ?
                                   bel_pkg::ERR_EMPTY_HEX : bel_pkg::ERR_EMPTY_BIN;
            mode_nxt = bel_pkg::MODE_DROP;
          end else begin
            res_a    = num_tok;
            res_b    = fr_res;
            mode_nxt = fr_mode;
            lead_nxt = is_dig ? char_r[3:0] : lead_r;
          end
        end
        default: begin
        end
      endcase
    end

    res_a.last = res_a.valid && !res_b.valid;
    res_b.last = 1'b1;
    push_cnt   = {1'b0, res_a.valid} + {1'b0, res_b.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bel_pkg::MODE_IDLE;
      lead_r <= '0;
      acc_r  <= '0;
      seen_r <= 1'b0;
    end else if (proc) begin
      mode_r <= mode_nxt;
      lead_r <= lead_nxt;
      acc_r  <= acc_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (proc) begin
        wr_ptr_r <= wr_ptr_r + bel_pkg::PTR_BITS'(push_cnt);
      end
      cnt_r <= cnt_r + (proc ? bel_pkg::CNT_BITS'(push_cnt) : '0)
                     - bel_pkg::CNT_BITS'(pop);
    end
    if (proc && res_a.valid) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (proc && res_b.valid) begin
      fifo_r[bel_pkg::PTR_BITS'(wr_ptr_r + 1'b1)] <= res_b;
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = bel_pkg::OUT_DATA_BITS'(fifo_r[rd_ptr_r].tok);
  assign out_tlast  = fifo_r[rd_ptr_r].last;

endmodule

// ===== hw/rtl/bel_checker.sv =====
`include "bitwise_expression_lexer_defines.svh"

module bel_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [bel_pkg::CHAR_BITS-1:0]     in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bel_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                              out_tlast
);

  bel_pkg::token_t tok;

  assign tok = out_tdata[bel_pkg::OUT_BITS-1:0];

  `BEL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BEL_ASSERT_NOW(a_err_only_on_error, out_tvalid && tok.token_kind != bel_pkg::KIND_ERROR, tok.error_code == bel_pkg::ERR_NONE)
  `BEL_ASSERT_NOW(a_error_has_code, out_tvalid && tok.token_kind == bel_pkg::KIND_ERROR, tok.error_code != bel_pkg::ERR_NONE && tok.number_value == '0)
  `BEL_ASSERT_NOW(a_end_is_last, out_tvalid && tok.token_kind == bel_pkg::KIND_END, out_tlast && tok.number_value == '0)
  `BEL_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata) && $stable(in_tuser))

endmodule

bind bitwise_expression_lexer bel_checker u_bel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== bench/bitwise_expression_lexer_checker.sv =====
module bitwise_expression_lexer_checker
  import bel_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [CHAR_BITS-1:0]     in_tdata,   // char_code[7:0]
  input  logic                     in_tuser,   // end_of_text
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,  // token_kind, number_value, error_code
  input  logic                     out_tlast,
  output int                       failures,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic   last;
    token_t tok;
  } lexed_token_t;

  lexed_token_t          expected_tokens[$];
  token_t                step_tokens[$];
  mode_t                 mode = MODE_IDLE;
  logic [3:0]            lead = '0;
  logic [VALUE_BITS-1:0] acc = '0;
  logic                  seen = 1'b0;
  int                    fail_count = 0;
  int                    waiting = 0;

  assign failures = fail_count;
  assign pending  = waiting;

  function automatic void push_token(logic [KIND_BITS-1:0] kind,
                                     logic [VALUE_BITS-1:0] value,
                                     logic [ERR_BITS-1:0] err);
    token_t t;
    t.token_kind   = kind;
    t.number_value = value;
    t.error_code   = err;
    step_tokens.push_back(t);
  endfunction

  function automatic void lex_error(logic [ERR_BITS-1:0] err);
    push_token(KIND_ERROR, '0, err);
    mode = MODE_DROP;
  endfunction

  // A digit that would carry the value past the top of its width is an overflow.
  function automatic void take_digit(int unsigned base, int unsigned digit);
    logic [63:0] wide;
    wide = 64'(acc) * 64'(base) + 64'(digit);
    if ((wide >> VALUE_BITS) != 0) begin
      lex_error(ERR_OVERFLOW);
    end else begin
      acc = wide[VALUE_BITS-1:0];
    end
  endfunction

  function automatic bit is_decimal(logic [CHAR_BITS-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int unsigned hex_digit(logic [CHAR_BITS-1:0] c);
    if (is_decimal(c)) return c - CH_ZERO;
    if (c >= CH_LA && c <= CH_LF_HEX) return c - CH_LA + 10;
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    return 16;
  endfunction

  function automatic void start_token(logic [CHAR_BITS-1:0] c);
    mode = MODE_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
    if (is_decimal(c)) begin
      lead = c[3:0];
      mode = MODE_LEAD;
    end else if (c == CH_AMP) begin
      push_token(KIND_AND, '0, ERR_NONE);
    end else if (c == CH_BAR) begin
      push_token(KIND_OR, '0, ERR_NONE);
    end else begin
      lex_error(ERR_BAD_CHAR);
    end
  endfunction

  // The character that closes a number is lexed again as the start of a token.
  function automatic void lex_character(logic [CHAR_BITS-1:0] c);
    int unsigned h;
    case (mode)
      MODE_IDLE: start_token(c);
      MODE_LEAD: begin
        if (c == CH_LX || c == CH_UX) begin
          mode = MODE_HEX;
          acc  = '0;
          seen = 1'b0;
        end else if (c == CH_LB || c == CH_UB) begin
          mode = MODE_BIN;
          acc  = '0;
          seen = 1'b0;
        end else if (is_decimal(c)) begin
          mode = MODE_DEC;
          seen = 1'b0;
          acc  = VALUE_BITS'(lead);
          take_digit(10, c - CH_ZERO);
        end else begin
          push_token(KIND_NUMBER, VALUE_BITS'(lead), ERR_NONE);
          start_token(c);
        end
      end
      MODE_HEX: begin
        h = hex_digit(c);
        if (h < 16) begin
          seen = 1'b1;
          take_digit(16, h);
        end else if (!seen) begin
          lex_error(ERR_EMPTY_HEX);
        end else begin
          push_token(KIND_NUMBER, acc, ERR_NONE);
          start_token(c);
        end
      end
      MODE_BIN: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          seen = 1'b1;
          take_digit(2, c - CH_ZERO);
        end else if (is_decimal(c)) begin
          lex_error(ERR_NONBINARY);
        end else if (!seen) begin
          lex_error(ERR_EMPTY_BIN);
        end else begin
          push_token(KIND_NUMBER, acc, ERR_NONE);
          start_token(c);
        end
      end
      MODE_DEC: begin
        if (is_decimal(c)) begin
          take_digit(10, c - CH_ZERO);
        end else begin
          push_token(KIND_NUMBER, acc, ERR_NONE);
          start_token(c);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void finish_text();
    case (mode)
      MODE_LEAD: push_token(KIND_NUMBER, VALUE_BITS'(lead), ERR_NONE);
      MODE_HEX: begin
        if (seen) push_token(KIND_NUMBER, acc, ERR_NONE);
        else push_token(KIND_ERROR, '0, ERR_EMPTY_HEX);
      end
      MODE_BIN: begin
        if (seen) push_token(KIND_NUMBER, acc, ERR_NONE);
        else push_token(KIND_ERROR, '0, ERR_EMPTY_BIN);
      end
      MODE_DEC: push_token(KIND_NUMBER, acc, ERR_NONE);
      default: ;
    endcase
    push_token(KIND_END, '0, ERR_NONE);
    mode = MODE_IDLE;
    lead = '0;
    acc  = '0;
    seen = 1'b0;
  endfunction

  function automatic void flag_failure(string detail);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, detail);
  endfunction

  always @(posedge clk) begin
    lexed_token_t entry;
    lexed_token_t want;
    token_t       got;
    if (!rst_n) begin
      expected_tokens.delete();
      mode = MODE_IDLE;
      lead = '0;
      acc  = '0;
      seen = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_tokens.delete();
        if (in_tuser) finish_text();
        else lex_character(in_tdata);
        foreach (step_tokens[i]) begin
          entry.tok  = step_tokens[i];
          entry.last = (i == step_tokens.size() - 1);
          expected_tokens.push_back(entry);
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_BITS-1:0];
        if (expected_tokens.size() == 0) begin
          flag_failure($sformatf("unexpected token: kind %0d value %0d error %0d last %0b",
                                 got.token_kind, got.number_value, got.error_code, out_tlast));
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind !== want.tok.token_kind ||
              got.number_value !== want.tok.number_value ||
              got.error_code !== want.tok.error_code || out_tlast !== want.last) begin
            flag_failure($sformatf({"token mismatch: expected kind %0d value %0d error %0d ",
                                    "last %0b, got kind %0d value %0d error %0d last %0b"},
                                   want.tok.token_kind, want.tok.number_value,
                                   want.tok.error_code, want.last, got.token_kind,
                                   got.number_value, got.error_code, out_tlast));
          end
        end
      end
    end
    waiting = expected_tokens.size();
  end

endmodule

// ===== bench/bitwise_expression_lexer_test.sv =====
module bitwise_expression_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bel_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 600;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [VALUE_BITS-1:0] MAX_VALUE = '1;
  localparam logic [CHAR_BITS-1:0] PREFIX_MARKS [4] = '{CH_LX, CH_UX, CH_LB, CH_UB};

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [CHAR_BITS-1:0]     in_tdata = '0;     // char_code[7:0]
  logic                     in_tuser = 1'b0;   // end_of_text
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;         // token_kind, number_value, error_code
  logic                     out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int chars_sent = 0;
  int cycle_count = 0;
  int mismatches;
  int tokens_waiting;

  bitwise_expression_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bitwise_expression_lexer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .failures   (mismatches),
    .pending    (tokens_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // A long hold-off lets the token queue fill so that the input side stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [CHAR_BITS-1:0] ch, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= eot;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [CHAR_BITS-1:0] ch);
    send_item(ch, 1'b0);
  endtask

  task automatic send_end();
    send_item(CHAR_BITS'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic string gap_text();
    string s;
    logic [CHAR_BITS-1:0] ch;
    s = "";
    if ($urandom_range(0, 1)) return s;
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 3))
        0: ch = CH_SPACE;
        1: ch = CH_TAB;
        2: ch = CH_LF;
        default: ch = CH_CR;
      endcase
      s = $sformatf("%s%c", s, ch);
    end
    return s;
  endfunction

  function automatic string mixed_case(string s);
    string up;
    up = s.toupper();
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(0, 1)) s[i] = up[i];
    return s;
  endfunction

  function automatic string number_text();
    logic [VALUE_BITS-1:0] v;
    int unsigned           lead;
    string                 pad;
    lead = $urandom_range(0, 9);
    pad  = ($urandom_range(0, 3) == 0) ? "00" : "";
    if ($urandom_range(0, 9) == 0) v = VALUE_BITS'($urandom());
    else v = VALUE_BITS'($urandom_range(0, 4095));
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", lead);
      1: return $sformatf("%0d", v);
      2: return $sformatf("%0d%c%s%s", lead, ($urandom_range(0, 1) ? CH_LX : CH_UX), pad,
                          mixed_case($sformatf("%0h", v)));
      3: return $sformatf("%0d%c%s%0b", lead, ($urandom_range(0, 1) ? CH_LB : CH_UB), pad, v);
      4: begin
        case ($urandom_range(0, 7))
          0: return $sformatf("%0d", MAX_VALUE);
          1: return $sformatf("%0d", 64'(MAX_VALUE) + 1);
          2: return $sformatf("0x%0h", MAX_VALUE);
          3: return $sformatf("9X%0h", 64'(MAX_VALUE) + 1);
          4: return $sformatf("1b%0b", MAX_VALUE);
          5: return $sformatf("0B%0b", 64'(MAX_VALUE) + 1);
          6: return "99999999999";
          default: return "00";
        endcase
      end
      default: return $sformatf("%0d", v[9:0]);
    endcase
  endfunction

  task automatic send_expression();
    int operands;
    operands = $urandom_range(1, 5);
    for (int i = 0; i < operands; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) begin
        send_text(gap_text());
        send_char($urandom_range(0, 1) ? CH_AMP : CH_BAR);
      end
      send_text(gap_text());
      send_text(number_text());
    end
    send_text(gap_text());
    send_end();
  endtask

  // Stray bytes, prefixes left empty, digits outside binary and dropped tails.
  task automatic send_broken();
    string digits;
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 6)) send_char(CHAR_BITS'($urandom_range(0, 255)));
      1: begin
        send_text($sformatf("%0d%c", $urandom_range(0, 9), PREFIX_MARKS[$urandom_range(0, 3)]));
        if ($urandom_range(0, 1)) send_char(CHAR_BITS'($urandom_range(0, 255)));
      end
      2: begin
        digits = $urandom_range(0, 1) ? $sformatf("%0b", $urandom_range(0, 15)) : "";
        send_text($sformatf("%0d%c%s%0d", $urandom_range(0, 9),
                            ($urandom_range(0, 1) ? CH_LB : CH_UB), digits,
                            $urandom_range(2, 9)));
      end
      default: repeat ($urandom_range(1, 6)) send_char(CHAR_BITS'($urandom_range(32, 126)));
    endcase
    repeat ($urandom_range(0, 3)) send_char(CHAR_BITS'($urandom_range(0, 255)));
    send_end();
  endtask

  task automatic run_random(input int quota);
    int first;
    first = chars_sent;
    while (chars_sent - first < quota) begin
      case ($urandom_range(0, 19))
        0: send_end();
        1, 2, 3: send_broken();
        default: send_expression();
      endcase
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 69;

    send_text("9|");
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_text("0x&");
    send_end();
    send_text("7B2");
    send_end();
    send_text("1b");
    send_end();
    send_char(8'h00);
    send_char(8'hFF);
    send_end();
    send_text("5X1f&");
    send_end();

    run_random(PHASE_ITEMS);
    send_idle_pct = 69;
    recv_idle_pct = 37;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (tokens_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
